>>> rtl/psc_pkg.sv
// ============================================================================
// Pressure sensor compensation package
// Shared widths, register indexes, pipeline stage map and arithmetic helpers.
// ============================================================================
package psc_pkg;

   localparam int unsigned RAW_W    = 20;
   localparam int unsigned OUT_W    = 32;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_COEFFS      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_COEFFS_LOW  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_COEFFS_HIGH = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_COEFF_LAST  = 8'd3;

   // Pipeline stage map.
   localparam int unsigned ST_CAPTURE   = 0;
   localparam int unsigned ST_TEMP_MUL  = 1;
   localparam int unsigned ST_TEMP_QUAD = 2;
   localparam int unsigned ST_TEMP_SUM  = 3;
   localparam int unsigned ST_OFF_MUL   = 4;
   localparam int unsigned ST_OSQ_MUL   = 5;
   localparam int unsigned ST_POLY_SUM  = 6;
   localparam int unsigned ST_SCALE_MUL = 7;
   localparam int unsigned ST_NUM_MUL   = 8;
   localparam int unsigned ST_DIV_PREP  = 9;
   localparam int unsigned DIV_STEPS    = 64;
   localparam int unsigned ST_DIV_FIRST = 10;
   localparam int unsigned ST_DIV_LAST  = ST_DIV_FIRST + DIV_STEPS - 1;
   localparam int unsigned ST_DIV_SIGN  = ST_DIV_LAST + 1;
   localparam int unsigned ST_SQ_PART  = ST_DIV_SIGN + 1;
   localparam int unsigned ST_SQ_SUM    = ST_SQ_PART + 1;
   localparam int unsigned ST_P9_MUL    = ST_SQ_SUM + 1;
   localparam int unsigned ST_CORR      = ST_P9_MUL + 1;
   localparam int unsigned ST_SCALE_OUT = ST_CORR + 1;
   localparam int unsigned NUM_STAGES   = ST_SCALE_OUT + 1;

   localparam logic signed [32:0] FINE_BIAS   = 33'sd128000;
   localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
   localparam logic [63:0]        SCALE_BIAS  = 64'h0000_8000_0000_0000;
   localparam logic signed [16:0] NUM_GAIN    = 17'sd3125;
   localparam logic signed [16:0] OUT_GAIN    = 17'sd100;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   typedef struct packed {
      logic [RAW_W-1:0]   rt;
      logic [RAW_W-1:0]   rp;
      logic [31:0]        lin;
      logic [31:0]        sq;
      logic [31:0]        tf;
      logic [31:0]        tc;
      logic signed [32:0] off;
      logic [20:0]        prd;
      logic [63:0]        osq;
      logic [63:0]        offp5;
      logic [63:0]        offp2;
      logic [63:0]        osqp6;
      logic [63:0]        osqp3;
      logic [63:0]        poff;
      logic [63:0]        psc0;
      logic [63:0]        pscp;
      logic [63:0]        nmr;
      logic [63:0]        psc;
      logic [63:0]        num;
      logic [63:0]        rem;
      logic [63:0]        nq;
      logic [63:0]        ad;
      logic               negq;
      logic               zero;
      logic [63:0]        pr;
      logic [63:0]        pll;
      logic [31:0]        plh;
      logic [63:0]        prp8;
      logic [63:0]        hh;
      logic [63:0]        hhp9;
      logic [63:0]        pr2;
      logic [31:0]        pout;
   } pipe_type;

   // Arithmetic right shift of a 64-bit pattern.
   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return 64'($signed(x) >>> n);
   endfunction

   // 64-bit by signed 17-bit product, wrapped to 64 bits, as two narrow multiplies.
   function automatic logic [63:0] mul64s17(input logic [63:0] a,
                                            input logic signed [16:0] b);
      logic signed [49:0] lo;
      logic signed [49:0] hi;
      lo = $signed({1'b0, a[31:0]}) * b;
      hi = $signed({1'b0, a[63:32]}) * b;
      return 64'(lo) + {hi[31:0], 32'b0};
   endfunction

   function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
      return 17'(v);
   endfunction

endpackage

>>> rtl/psc_req_if.sv
// ============================================================================
// Raw reading channel
// Carries one raw temperature and raw pressure pair per beat.
// ============================================================================
interface psc_req_if;
   import psc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_temperature;
   logic [RAW_W-1:0] raw_pressure;
   modport source(output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

>>> rtl/psc_rsp_if.sv
// ============================================================================
// Compensated result channel
// Carries fine temperature, centidegree temperature and pressure per beat.
// ============================================================================
interface psc_rsp_if;
   import psc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] fine_temperature;
   logic signed [OUT_W-1:0] temperature_centi;
   logic [OUT_W-1:0]        pressure_value;
   modport source(output valid, output fine_temperature, output temperature_centi,
                  output pressure_value, input ready);
   modport sink(input valid, input fine_temperature, input temperature_centi,
                input pressure_value, output ready);
endinterface

>>> rtl/psc_csr_if.sv
// ============================================================================
// Configuration write channel
// Carries one register index and its write data per beat.
// ============================================================================
interface psc_csr_if;
   import psc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/pressure_sensor_compensation.sv
// ============================================================================
// Pressure sensor compensation
// Fully pipelined integer compensation of raw temperature and pressure.
// ============================================================================
// The block accepts one raw reading pair per cycle while req.ready is high and
// returns one result per pair, in order. Each result is held in the last
// stage's register and can be taken at the next edge. Most of the pipeline is
// the 64-bit signed division, which is unrolled into 64 pipeline stages that
// each settle one quotient bit; the remaining stages capture the readings or
// hold the multiplies, sums and sign steps around it. Every stage has its
// own valid bit and moves whenever the stage after it is free, so bubbles
// close up and the input keeps flowing while a finished result waits on the
// output register, as long as some stage upstream is still empty. Calibration
// is written through the configuration channel, which is always ready; it
// must only be written while no beat is in flight.
module pressure_sensor_compensation (
   input  logic      clock,
   input  logic      reset,
   psc_req_if.sink   req,
   psc_rsp_if.source rsp,
   psc_csr_if.sink   csr
);
   import psc_pkg::*;

   // Calibration registers as written.
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_last_ff;
   coef_type    coef;

   pipe_type pipe_ff [NUM_STAGES];
   pipe_type pipe_in [NUM_STAGES];
   logic     valid_ff [NUM_STAGES];
   logic     adv [NUM_STAGES];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_last_ff  <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_TEMP_COEFFS:       temp_coeffs_ff <= csr.data[47:0];
            REG_PRESS_COEFFS_LOW:  press_low_ff   <= csr.data;
            REG_PRESS_COEFFS_HIGH: press_high_ff  <= csr.data;
            REG_PRESS_COEFF_LAST:  press_last_ff  <= csr.data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the coefficient slices.
   always_comb begin
      coef.t1 = temp_coeffs_ff[15:0];
      coef.t2 = $signed(temp_coeffs_ff[31:16]);
      coef.t3 = $signed(temp_coeffs_ff[47:32]);
      coef.p1 = press_low_ff[15:0];
      coef.p2 = $signed(press_low_ff[31:16]);
      coef.p3 = $signed(press_low_ff[47:32]);
      coef.p4 = $signed(press_low_ff[63:48]);
      coef.p5 = $signed(press_high_ff[15:0]);
      coef.p6 = $signed(press_high_ff[31:16]);
      coef.p7 = $signed(press_high_ff[47:32]);
      coef.p8 = $signed(press_high_ff[63:48]);
      coef.p9 = $signed(press_last_ff);
   end

   // Work of one stage on the contents of the stage before it.
   function automatic pipe_type stage_work(input int unsigned st, input pipe_type x,
                                           input coef_type c);
      pipe_type           y;
      logic [31:0]        d1;
      logic [31:0]        d2;
      logic signed [47:0] p48;
      logic [31:0]        quad;
      logic signed [65:0] p66;
      logic signed [48:0] p49;
      logic [64:0]        rs;
      logic [63:0]        h;
      logic [63:0]        corr;
      y = x;
      if (st >= ST_DIV_FIRST && st <= ST_DIV_LAST) begin
         // One restoring division step: shift in a numerator bit, try a subtract.
         rs = {x.rem, x.nq[63]};
         y.nq = {x.nq[62:0], 1'b0};
         if (rs >= {1'b0, x.ad}) begin
            rs = rs - {1'b0, x.ad};
            y.nq[0] = 1'b1;
         end
         y.rem = rs[63:0];
      end else begin
         case (st)
            ST_TEMP_MUL: begin
               d1 = {15'b0, x.rt[19:3]} - {15'b0, c.t1, 1'b0};
               p48 = $signed(d1) * c.t2;
               y.lin = p48[31:0];
               d2 = {16'b0, x.rt[19:4]} - {16'b0, c.t1};
               y.sq = d2 * d2;
            end
            ST_TEMP_QUAD: begin
               y.lin = 32'($signed(x.lin) >>> 11);
               p48 = $signed(32'($signed(x.sq) >>> 12)) * c.t3;
               y.sq = p48[31:0];
            end
            ST_TEMP_SUM: begin
               quad = 32'($signed(x.sq) >>> 14);
               y.tf = x.lin + quad;
               y.tc = (y.tf << 2) + y.tf + 32'd128;
               y.off = 33'($signed(y.tf)) - FINE_BIAS;
            end
            ST_OFF_MUL: begin
               y.tc = 32'($signed(x.tc) >>> 8);
               p66 = x.off * x.off;
               y.osq = p66[63:0];
               p49 = x.off * c.p5;
               y.offp5 = 64'(p49);
               p49 = x.off * c.p2;
               y.offp2 = 64'(p49);
               y.prd = PRESS_FULL - {1'b0, x.rp};
            end
            ST_OSQ_MUL: begin
               y.osqp6 = mul64s17(x.osq, sx17(c.p6));
               y.osqp3 = mul64s17(x.osq, sx17(c.p3));
            end
            ST_POLY_SUM: begin
               y.poff = x.osqp6 + (x.offp5 << 17) + (64'(c.p4) << 35);
               y.psc0 = asr64(x.osqp3, 8) + (x.offp2 << 12);
            end
            ST_SCALE_MUL: begin
               y.pscp = mul64s17(SCALE_BIAS + x.psc0, $signed({1'b0, c.p1}));
               y.nmr = ({43'b0, x.prd} << 31) - x.poff;
            end
            ST_NUM_MUL: begin
               y.psc = asr64(x.pscp, 33);
               y.num = mul64s17(x.nmr, NUM_GAIN);
            end
            ST_DIV_PREP: begin
               y.nq = x.num[63] ? (64'd0 - x.num) : x.num;
               y.ad = x.psc[63] ? (64'd0 - x.psc) : x.psc;
               y.negq = x.num[63] ^ x.psc[63];
               y.zero = (x.psc == 64'd0);
               y.rem = '0;
            end
            ST_DIV_SIGN: begin
               y.pr = x.negq ? (64'd0 - x.nq) : x.nq;
            end
            ST_SQ_PART: begin
               // The square of h needs the low product and one cross term.
               h = asr64(x.pr, 13);
               y.pll = h[31:0] * h[31:0];
               y.plh = h[31:0] * h[63:32];
               y.prp8 = mul64s17(x.pr, sx17(c.p8));
            end
            ST_SQ_SUM: begin
               y.hh = x.pll + {x.plh[30:0], 1'b0, 32'b0};
            end
            ST_P9_MUL: begin
               y.hhp9 = mul64s17(x.hh, sx17(c.p9));
            end
            ST_CORR: begin
               corr = asr64(x.hhp9, 25) + asr64(x.prp8, 19);
               y.pr2 = asr64(x.pr + corr, 8) + (64'(c.p7) << 4);
            end
            ST_SCALE_OUT: begin
               h = asr64(mul64s17(x.pr2, OUT_GAIN), 8);
               y.pout = x.zero ? 32'd0 : h[31:0];
            end
            default: begin
            end
         endcase
      end
      return y;
   endfunction

   // Stage 0 captures the raw readings; every later stage works on its predecessor.
   always_comb begin
      pipe_in[ST_CAPTURE]    = pipe_ff[ST_CAPTURE];
      pipe_in[ST_CAPTURE].rt = req.raw_temperature;
      pipe_in[ST_CAPTURE].rp = req.raw_pressure;
   end

   for (genvar s = 1; s < NUM_STAGES; s++) begin : g_work
      always_comb pipe_in[s] = stage_work(s, pipe_ff[s-1], coef);
   end

   // A stage may load when it is empty or its contents move on this cycle.
   assign adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
   for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_adv
      assign adv[s] = !valid_ff[s] || adv[s+1];
   end

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= (s == 0) ? req.valid : valid_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign req.ready             = adv[0];
   assign rsp.valid             = valid_ff[NUM_STAGES-1];
   assign rsp.fine_temperature  = $signed(pipe_ff[NUM_STAGES-1].tf);
   assign rsp.temperature_centi = $signed(pipe_ff[NUM_STAGES-1].tc);
   assign rsp.pressure_value    = pipe_ff[NUM_STAGES-1].pout;

endmodule

>>> sim/pressure_sensor_compensation_test.sv
// ============================================================================
// Pressure sensor compensation testbench
// Drives raw reading pairs through the pipeline under bursty input and a
// stalling output, predicts each result from the calibration in use, and
// compares every returned beat field by field in order.
// ============================================================================

// Scoreboard: predicts compensated results and holds them until they return.
class psc_scoreboard;
   logic [47:0] temp_coeffs;
   logic [63:0] press_low;
   logic [63:0] press_high;
   logic [15:0] press_last;
   logic [95:0] pending[$];
   int          failures;

   function new();
      temp_coeffs = '0;
      press_low   = '0;
      press_high  = '0;
      press_last  = '0;
      failures    = 0;
   endfunction

   function void write_reg(logic [7:0] index, logic [63:0] value);
      case (index)
         psc_pkg::REG_TEMP_COEFFS:       temp_coeffs = value[47:0];
         psc_pkg::REG_PRESS_COEFFS_LOW:  press_low   = value;
         psc_pkg::REG_PRESS_COEFFS_HIGH: press_high  = value;
         psc_pkg::REG_PRESS_COEFF_LAST:  press_last  = value[15:0];
         default: ;
      endcase
   endfunction

   // Works out fine temperature, centidegrees and pressure for one beat.
   function void note_reading(logic [19:0] rt, logic [19:0] rp);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [31:0] d1, lin, d2, sq, quad, tf, tc, w;
      logic signed [63:0] off, osq, poff, psc, pr, num, h, corr;
      logic [63:0]        an, ad, q;
      logic [31:0]        pout;
      t1 = {48'd0, temp_coeffs[15:0]};
      t2 = $signed(temp_coeffs[31:16]);
      t3 = $signed(temp_coeffs[47:32]);
      p1 = {48'd0, press_low[15:0]};
      p2 = $signed(press_low[31:16]);
      p3 = $signed(press_low[47:32]);
      p4 = $signed(press_low[63:48]);
      p5 = $signed(press_high[15:0]);
      p6 = $signed(press_high[31:16]);
      p7 = $signed(press_high[47:32]);
      p8 = $signed(press_high[63:48]);
      p9 = $signed(press_last);
      // Temperature path wraps at 32 bits after every operation.
      d1   = 32'({44'd0, rt} >> 3) - 32'(t1 << 1);
      w    = 32'(64'(d1) * t2);
      lin  = w >>> 11;
      d2   = 32'({44'd0, rt} >> 4) - 32'(t1);
      w    = d2 * d2;
      sq   = w >>> 12;
      w    = 32'(64'(sq) * t3);
      quad = w >>> 14;
      tf   = lin + quad;
      w    = tf * 32'sd5 + 32'sd128;
      tc   = w >>> 8;
      // Pressure path wraps at 64 bits.
      off  = 64'(tf) - 64'sd128000;
      osq  = off * off;
      poff = osq * p6 + ((off * p5) <<< 17) + (p4 <<< 35);
      psc  = ((osq * p3) >>> 8) + ((off * p2) <<< 12);
      psc  = (((64'sd1 <<< 47) + psc) * p1) >>> 33;
      pout = '0;
      if (psc != 0) begin
         pr  = 64'sd1048576 - $signed({44'd0, rp});
         num = ((pr <<< 31) - poff) * 64'sd3125;
         an  = num[63] ? -num : num;
         ad  = psc[63] ? -psc : psc;
         q   = an / ad;
         pr  = (num[63] != psc[63]) ? -$signed(q) : $signed(q);
         h   = pr >>> 13;
         corr = (((h * h) * p9) >>> 25) + ((pr * p8) >>> 19);
         pr  = ((pr + corr) >>> 8) + (p7 <<< 4);
         pr  = (pr * 64'sd100) >>> 8;
         pout = pr[31:0];
      end
      pending.push_back({tf, tc, pout});
   endfunction

   function void check_result(logic [31:0] tf, logic [31:0] tc, logic [31:0] pv);
      logic [95:0] exp_beat;
      if (pending.size() == 0) begin
         $error("result beat with no reading outstanding");
         failures++;
         return;
      end
      exp_beat = pending.pop_front();
      if (exp_beat[95:64] !== tf) begin
         $error("fine_temperature expected %0d actual %0d",
                $signed(exp_beat[95:64]), $signed(tf));
         failures++;
      end
      if (exp_beat[63:32] !== tc) begin
         $error("temperature_centi expected %0d actual %0d",
                $signed(exp_beat[63:32]), $signed(tc));
         failures++;
      end
      if (exp_beat[31:0] !== pv) begin
         $error("pressure_value expected %0d actual %0d", exp_beat[31:0], pv);
         failures++;
      end
   endfunction
endclass

module pressure_sensor_compensation_test;
   timeunit 1ns;
   timeprecision 1ps;
   import psc_pkg::*;

   localparam int LATENCY = NUM_STAGES + 8;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic stall_mode = 1'b0;
   int   cycle_count = 0;

   psc_req_if req();
   psc_rsp_if rsp();
   psc_csr_if csr();

   psc_scoreboard board = new();

   pressure_sensor_compensation dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The output side follows its own stall pattern: some stretches always
   // ready, others dropping ready on a random fraction of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // Every returned beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(rsp.fine_temperature, rsp.temperature_centi,
                            rsp.pressure_value);
   end

   // Watchdog: a stuck pipeline ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Writes one calibration register; the pipeline must be empty.
   task automatic write_csr(logic [7:0] index, logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      board.write_reg(index, value);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one reading pair. The valid line stays high across back-to-back
   // beats of a burst; only the burst end lowers it.
   task automatic send_reading(logic [19:0] rt, logic [19:0] rp, bit last_of_burst);
      req.valid <= 1'b1;
      req.raw_temperature <= rt;
      req.raw_pressure <= rp;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_reading(rt, rp);
      if (last_of_burst) req.valid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Loads a full calibration set, covering every register.
   task automatic load_calibration(logic [47:0] tc, logic [63:0] pl,
                                   logic [63:0] ph, logic [15:0] p9);
      write_csr(REG_TEMP_COEFFS, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | tc);
      write_csr(REG_PRESS_COEFFS_LOW, pl);
      write_csr(REG_PRESS_COEFFS_HIGH, ph);
      write_csr(REG_PRESS_COEFF_LAST, 64'({$urandom, 16'h0} | p9));
   endtask

   // Random traffic in bursts, mostly realistic readings with some noise.
   // A burst that is followed by no gap runs straight into the next one.
   task automatic random_traffic(int count);
      int sent, burst, k, gap;
      logic [19:0] rt, rp;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 30)) : 0;
         for (k = 0; k < burst && sent < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               rt = 20'($urandom); rp = 20'($urandom);
            end else begin
               rt = 20'($urandom_range(380000, 650000));
               rp = 20'($urandom_range(200000, 500000));
            end
            send_reading(rt, rp, (gap != 0 && k == burst - 1) || (sent == count - 1));
            sent++;
         end
         if (gap != 0) repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [63:0] pl, ph;
      int i;
      req.valid <= 1'b0;
      req.raw_temperature <= '0;
      req.raw_pressure <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All-zero calibration: the divisor is zero, so pressure reads 0.
      send_reading(20'h00000, 20'h00000, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
      drain();

      // Typical factory calibration.
      load_calibration({16'hD0BD, 16'h6666, 16'h6C70},
                       {16'h0B49, 16'hD0BD, 16'hD5D0, 16'h8E9C},
                       {16'h1770, 16'h3C14, 16'h003C, 16'hFFF9}, 16'h1770);
      send_reading(20'h00000, 20'h00000, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_reading(20'h00000, 20'hFFFFF, 1'b0);
      send_reading(20'hFFFFF, 20'h00000, 1'b0);
      send_reading(20'd519888, 20'd415148, 1'b0);
      send_reading(20'h80000, 20'h80000, 1'b1);
      drain();

      // Extreme coefficients, including most negative and all ones.
      load_calibration(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                       64'h8000_8000_8000_8000, 16'h8000);
      send_reading(20'h00000, 20'hFFFFF, 1'b0);
      send_reading(20'hFFFFF, 20'h00000, 1'b0);
      send_reading(20'h55555, 20'hAAAAA, 1'b1);
      drain();
      load_calibration(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
                       64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
      send_reading(20'hAAAAA, 20'h55555, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
      drain();

      // An index beyond the register list changes nothing.
      write_csr(8'hFF, {$urandom, $urandom});
      send_reading(20'h12345, 20'h6789A, 1'b1);
      drain();

      // Random phases: realistic calibration in every other phase, random bits
      // otherwise, so the scale term sometimes collapses to zero.
      for (i = 0; i < 6; i++) begin
         if (i % 2 == 0) begin
            pl = {16'($signed(-$urandom_range(0, 5000))), 16'($urandom_range(0, 5000)),
                  16'($signed(-$urandom_range(0, 12000))), 16'($urandom_range(20000, 40000))};
            ph = {16'($urandom_range(0, 20000)), 16'($urandom_range(0, 200)),
                  16'($signed(-$urandom_range(0, 20))), 16'($urandom_range(0, 30000))};
            load_calibration({16'($urandom_range(0, 300)), 16'($urandom_range(20000, 30000)),
                              16'($urandom_range(20000, 30000))},
                             pl, ph, 16'($urandom_range(0, 8000)));
         end else begin
            load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                             {$urandom, $urandom}, 16'($urandom));
         end
         random_traffic(105);
         drain();
      end

      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
